>>> hw/rtl/whp_pkg.sv
// Package for the WAV RIFF header parser: item types, tag constants, status codes.
// No dependencies; imported by the parser top level and its checker.
package whp_pkg;

    // Default minimum file length in bytes
    localparam int unsigned MIN_FILE_BYTES_DEF = 44;

    // Chunk tags, first byte in the most significant lane
    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666d_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    // Smallest legal fmt chunk body
    localparam logic [31:0] FMT_MIN_LEN = 32'd16;

    // Summary status codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_TOO_SMALL = 3'd1,
        ST_NOT_WAVE  = 3'd2,
        ST_BAD_FMT   = 3'd3,
        ST_NOT_PCM   = 3'd4,
        ST_MISSING   = 3'd5
    } t_status;

    // One input item: a file byte and its last-byte flag
    typedef struct packed {
        logic [7:0] file_byte;
        logic       final_byte;
    } t_in_item;

    // One result item
    typedef struct packed {
        logic        pcm_valid;
        logic [7:0]  pcm_byte;
        logic        done_res;
        logic [2:0]  status;
        logic [15:0] channels;
        logic [31:0] rate_hz;
        logic [15:0] sample_depth;
        logic [31:0] data_length;
        logic [31:0] sample_frames;
    } t_out_item;

endpackage

>>> hw/rtl/whp_stream_if.sv
// Valid/ready stream channel with a typed payload.
// No dependencies; the payload type is set per instance.
interface whp_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/wav_riff_header_parser_unit.sv
// WAV RIFF header parser: one file byte per item in, one result item per byte out.
// Results are registered, valid in the cycle after the byte is accepted, except a final byte
// with status ok: it waits for the shared shift-subtract divider, 32 steps for bytes per
// sample and 32 for channels. Throughput: one byte per cycle while results are taken
// and the divider is idle. Reset (i_rst_n low, synchronous) returns the parser to the RIFF
// tag and drops any result. Depends on whp_pkg and whp_stream_if.
module wav_riff_header_parser_unit
    import whp_pkg::*;
#(
    parameter int unsigned MIN_FILE_BYTES = MIN_FILE_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    whp_stream_if.sink          i_in,
    whp_stream_if.source        o_out
);

    typedef enum logic [2:0] {
        PH_RIFF,
        PH_HDR,
        PH_FMT,
        PH_DATA,
        PH_SKIP,
        PH_PAD,
        PH_STOP
    } t_phase;

    typedef enum logic [1:0] {
        CT_IDLE,
        CT_DIV_BPS,
        CT_DIV_CH
    } t_ctrl;

    // Parser state
    t_phase      r_phase,    n_phase;
    logic [31:0] r_offset,   n_offset;
    logic [31:0] r_tag,      n_tag;
    logic [31:0] r_len,      n_len;
    logic [31:0] r_left,     n_left;
    logic        r_pad,      n_pad;
    logic        r_fmt_seen, n_fmt_seen;
    logic        r_data_seen, n_data_seen;
    logic [15:0] r_ch,       n_ch;
    logic [31:0] r_rate,     n_rate;
    logic [15:0] r_bits,     n_bits;
    logic [31:0] r_payload,  n_payload;
    logic [2:0]  r_err,      n_err;
    logic        r_not_pcm,  n_not_pcm;

    // Sequencer and divider
    t_ctrl       r_ctrl;
    logic [31:0] r_quot,     n_quot;
    logic [15:0] r_rem,      n_rem;
    logic [15:0] r_div;
    logic [4:0]  r_cnt;

    // Output register
    logic        r_out_valid;
    t_out_item   r_out_data;

    logic        w_accept;
    logic [7:0]  w_b;
    logic [31:0] w_pos;
    logic [12:0] w_bps;
    t_status     w_st;
    t_out_item   w_item;
    logic [16:0] w_rem_sh;
    logic [16:0] w_diff;

    assign w_b      = i_in.data.file_byte;
    assign i_in.ready = (r_ctrl == CT_IDLE) && (!r_out_valid || o_out.ready);
    assign w_accept = i_in.valid && i_in.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

    // Parse one byte
    always_comb begin
        n_phase     = r_phase;
        n_offset    = r_offset;
        n_tag       = r_tag;
        n_len       = r_len;
        n_left      = r_left;
        n_pad       = r_pad;
        n_fmt_seen  = r_fmt_seen;
        n_data_seen = r_data_seen;
        n_ch        = r_ch;
        n_rate      = r_rate;
        n_bits      = r_bits;
        n_payload   = r_payload;
        n_err       = r_err;
        n_not_pcm   = r_not_pcm;
        w_pos       = r_len - r_left;
        w_item      = '0;

        case (r_phase)
            PH_RIFF: begin
                n_tag = {r_tag[23:0], w_b};
                if (r_offset == 32'd3 && n_tag != TAG_RIFF) begin
                    n_err   = ST_NOT_WAVE;
                    n_phase = PH_STOP;
                end else if (r_offset == 32'd11) begin
                    if (n_tag != TAG_WAVE) begin
                        n_err   = ST_NOT_WAVE;
                        n_phase = PH_STOP;
                    end else begin
                        n_phase = PH_HDR;
                        n_left  = '0;
                        n_tag   = '0;
                        n_len   = '0;
                    end
                end
            end
            PH_HDR: begin
                // Tag bytes first, then the little-endian length
                if (r_left < 32'd4) begin
                    n_tag = {r_tag[23:0], w_b};
                end else begin
                    case (r_left[1:0])
                        2'd0:    n_len[7:0]   = r_len[7:0]   | w_b;
                        2'd1:    n_len[15:8]  = r_len[15:8]  | w_b;
                        2'd2:    n_len[23:16] = r_len[23:16] | w_b;
                        default: n_len[31:24] = r_len[31:24] | w_b;
                    endcase
                end
                n_left = r_left + 32'd1;
                // Header complete: open the body
                if (n_left >= 32'd8) begin
                    n_pad  = n_len[0];
                    n_left = n_len;
                    if (n_tag == TAG_FMT) begin
                        if (n_len < FMT_MIN_LEN) begin
                            n_err   = ST_BAD_FMT;
                            n_phase = PH_STOP;
                        end else begin
                            n_phase   = PH_FMT;
                            n_not_pcm = 1'b0;
                        end
                    end else begin
                        if (n_tag == TAG_DATA && !r_data_seen) begin
                            n_data_seen = 1'b1;
                            n_phase     = PH_DATA;
                        end else begin
                            n_phase = PH_SKIP;
                        end
                        // Empty body: straight to the next header
                        if (n_len == 32'd0) begin
                            n_phase = PH_HDR;
                            n_left  = '0;
                            n_tag   = '0;
                            n_len   = '0;
                        end
                    end
                end
            end
            PH_FMT, PH_DATA, PH_SKIP: begin
                if (r_phase == PH_FMT) begin
                    if (w_pos == 32'd0) begin
                        n_not_pcm = (w_b != 8'd1);
                    end else if (w_pos == 32'd1) begin
                        n_not_pcm = r_not_pcm || (w_b != 8'd0);
                    end else if (w_pos == 32'd2) begin
                        n_ch[7:0] = w_b;
                    end else if (w_pos == 32'd3) begin
                        n_ch[15:8] = w_b;
                    end else if (w_pos >= 32'd4 && w_pos <= 32'd7) begin
                        case (w_pos[1:0])
                            2'd0:    n_rate[7:0]   = w_b;
                            2'd1:    n_rate[15:8]  = w_b;
                            2'd2:    n_rate[23:16] = w_b;
                            default: n_rate[31:24] = w_b;
                        endcase
                    end else if (w_pos == 32'd14) begin
                        n_bits[7:0] = w_b;
                    end else if (w_pos == 32'd15) begin
                        n_bits[15:8] = w_b;
                    end
                end else if (r_phase == PH_DATA) begin
                    w_item.pcm_valid = 1'b1;
                    w_item.pcm_byte  = w_b;
                    if (r_payload != '1) begin
                        n_payload = r_payload + 32'd1;
                    end
                end
                if (r_left != 32'd0) begin
                    n_left = r_left - 32'd1;
                end
                // Body finished
                if (n_left == 32'd0) begin
                    if (r_phase == PH_FMT && n_not_pcm) begin
                        n_err   = ST_NOT_PCM;
                        n_phase = PH_STOP;
                    end else begin
                        if (r_phase == PH_FMT) begin
                            n_fmt_seen = 1'b1;
                        end
                        if (r_pad) begin
                            n_phase = PH_PAD;
                        end else begin
                            n_phase = PH_HDR;
                            n_left  = '0;
                            n_tag   = '0;
                            n_len   = '0;
                        end
                    end
                end
            end
            PH_PAD: begin
                n_phase = PH_HDR;
                n_left  = '0;
                n_tag   = '0;
                n_len   = '0;
            end
            default: begin
            end
        endcase

        if (r_offset != '1) begin
            n_offset = r_offset + 32'd1;
        end

        // Summary on the final byte
        w_bps = n_bits[15:3];
        if (n_offset < 32'(MIN_FILE_BYTES)) begin
            w_st = ST_TOO_SMALL;
        end else if (n_err != ST_OK) begin
            w_st = t_status'(n_err);
        end else if (n_phase == PH_FMT) begin
            w_st = ST_BAD_FMT;
        end else if (!n_fmt_seen || !n_data_seen || n_payload == 32'd0) begin
            w_st = ST_MISSING;
        end else if (w_bps == 13'd0 || n_ch == 16'd0) begin
            w_st = ST_BAD_FMT;
        end else begin
            w_st = ST_OK;
        end

        if (i_in.data.final_byte) begin
            w_item.done_res = 1'b1;
            w_item.status   = w_st;
            if (w_st == ST_OK) begin
                w_item.channels     = n_ch;
                w_item.rate_hz      = n_rate;
                w_item.sample_depth = n_bits;
                w_item.data_length  = n_payload;
            end
        end
    end

    // Shared restoring divider step: one quotient bit per cycle
    always_comb begin
        w_rem_sh = {r_rem, r_quot[31]};
        w_diff   = w_rem_sh - {1'b0, r_div};
        if (w_rem_sh >= {1'b0, r_div}) begin
            n_rem  = w_diff[15:0];
            n_quot = {r_quot[30:0], 1'b1};
        end else begin
            n_rem  = w_rem_sh[15:0];
            n_quot = {r_quot[30:0], 1'b0};
        end
    end

    // Hold state, sequence the divider, drive the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_RIFF;
            r_offset    <= '0;
            r_tag       <= '0;
            r_len       <= '0;
            r_left      <= '0;
            r_pad       <= 1'b0;
            r_fmt_seen  <= 1'b0;
            r_data_seen <= 1'b0;
            r_ch        <= '0;
            r_rate      <= '0;
            r_bits      <= '0;
            r_payload   <= '0;
            r_err       <= '0;
            r_not_pcm   <= 1'b0;
            r_ctrl      <= CT_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_ctrl)
                CT_IDLE: begin
                    if (w_accept) begin
                        if (i_in.data.final_byte) begin
                            // Back to the reset state for the next file
                            r_phase     <= PH_RIFF;
                            r_offset    <= '0;
                            r_tag       <= '0;
                            r_len       <= '0;
                            r_left      <= '0;
                            r_pad       <= 1'b0;
                            r_fmt_seen  <= 1'b0;
                            r_data_seen <= 1'b0;
                            r_ch        <= '0;
                            r_rate      <= '0;
                            r_bits      <= '0;
                            r_payload   <= '0;
                            r_err       <= '0;
                            r_not_pcm   <= 1'b0;
                        end else begin
                            r_phase     <= n_phase;
                            r_offset    <= n_offset;
                            r_tag       <= n_tag;
                            r_len       <= n_len;
                            r_left      <= n_left;
                            r_pad       <= n_pad;
                            r_fmt_seen  <= n_fmt_seen;
                            r_data_seen <= n_data_seen;
                            r_ch        <= n_ch;
                            r_rate      <= n_rate;
                            r_bits      <= n_bits;
                            r_payload   <= n_payload;
                            r_err       <= n_err;
                            r_not_pcm   <= n_not_pcm;
                        end
                        r_out_data <= w_item;
                        if (i_in.data.final_byte && w_st == ST_OK) begin
                            // Frames still to compute: start with bytes per sample
                            r_out_valid <= 1'b0;
                            r_quot      <= n_payload;
                            r_rem       <= '0;
                            r_div       <= {3'd0, w_bps};
                            r_cnt       <= '0;
                            r_ctrl      <= CT_DIV_BPS;
                        end else begin
                            r_out_valid <= 1'b1;
                        end
                    end else if (o_out.ready) begin
                        // Drop the result once taken
                        r_out_valid <= 1'b0;
                    end
                end
                CT_DIV_BPS: begin
                    r_quot <= n_quot;
                    r_cnt  <= r_cnt + 5'd1;
                    if (r_cnt == '1) begin
                        // Second pass divides the quotient by channels
                        r_rem  <= '0;
                        r_div  <= r_out_data.channels;
                        r_ctrl <= CT_DIV_CH;
                    end else begin
                        r_rem  <= n_rem;
                    end
                end
                CT_DIV_CH: begin
                    r_quot <= n_quot;
                    r_rem  <= n_rem;
                    r_cnt  <= r_cnt + 5'd1;
                    if (r_cnt == '1) begin
                        r_out_data.sample_frames <= n_quot;
                        r_out_valid              <= 1'b1;
                        r_ctrl                   <= CT_IDLE;
                    end
                end
                default: begin
                    r_ctrl <= CT_IDLE;
                end
            endcase
        end
    end

endmodule

>>> hw/rtl/whp_checker.sv
// Port-level checks for the WAV RIFF header parser, attached by bind.
// Depends on whp_pkg and wav_riff_header_parser_unit.
module whp_checker
    import whp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  logic      i_in_final,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_data
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result changed while stalled");

    // Take no item while an untaken result waits
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |-> !i_out_valid || i_out_ready)
        else $error("item accepted over a waiting result");

    // Answer an ordinary byte in the next cycle
    a_byte_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && !i_in_final |=> i_out_valid)
        else $error("no result one cycle after a non-final item");

    // Zero the byte lane when no data byte is carried
    a_pcm_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_data.pcm_valid |-> i_out_data.pcm_byte == 8'd0)
        else $error("pcm byte set without pcm valid");

    // Zero the summary unless the file parsed cleanly
    a_summary_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.status != ST_OK |->
            i_out_data.channels == 16'd0 && i_out_data.rate_hz == 32'd0 &&
            i_out_data.data_length == 32'd0 && i_out_data.sample_frames == 32'd0)
        else $error("summary fields set with error status");

endmodule

bind wav_riff_header_parser_unit whp_checker u_whp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_final  (i_in.data.final_byte),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);

>>> tb/tb_wav_riff_header_parser_unit.sv
// Self-checking testbench for the WAV RIFF header parser: byte driver, result monitor,
// and a byte-level predictor of the chunk walk. Depends on whp_pkg, whp_stream_if and
// wav_riff_header_parser_unit.
`timescale 1ns / 1ps

module tb_wav_riff_header_parser_unit;
    import whp_pkg::*;

    // Extra tags used to build files
    localparam logic [31:0] TAG_LIST = 32'h4c49_5354;
    localparam logic [31:0] TAG_RIFX = 32'h5249_4658;
    localparam logic [31:0] TAG_AVI  = 32'h4156_4920;

    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_BYTES  = 100;
    localparam int TAIL_CYCLES  = 100;

    // Walk position inside the file
    typedef enum logic [2:0] {
        W_RIFF, W_HDR, W_FMT, W_DATA, W_SKIP, W_PAD, W_STOP
    } t_walk;

    logic i_clk;
    logic i_rst_n;

    whp_stream_if #(.T(t_in_item))  in_if ();
    whp_stream_if #(.T(t_out_item)) out_if ();

    wav_riff_header_parser_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_in_item   pend_q[$];
    t_out_item  exp_q[$];
    logic [7:0] file_buf[$];

    int   tx_idle_pct;
    int   rx_stall_pct;
    int   err_cnt = 0;
    int   items_sent;
    logic start_hold;
    logic hold_rx;

    // Predictor state
    logic [31:0] pos_cnt;
    t_walk       walk;
    logic [31:0] hdr_word;
    logic [31:0] chunk_len;
    logic [32:0] body_left;
    logic        pad_due;
    logic        have_fmt;
    logic        have_data;
    logic [15:0] fmt_chan;
    logic [31:0] fmt_rate;
    logic [15:0] fmt_bits;
    logic [31:0] pcm_count;
    t_status     latched_st;
    logic        fmt_code_bad;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void clear_parser();
        pos_cnt      = '0;
        walk         = W_RIFF;
        hdr_word     = '0;
        chunk_len    = '0;
        body_left    = '0;
        pad_due      = 1'b0;
        have_fmt     = 1'b0;
        have_data    = 1'b0;
        fmt_chan     = '0;
        fmt_rate     = '0;
        fmt_bits     = '0;
        pcm_count    = '0;
        latched_st   = ST_OK;
        fmt_code_bad = 1'b0;
    endfunction

    function automatic void latch_error(input t_status code);
        latched_st = code;
        walk       = W_STOP;
    endfunction

    function automatic void next_chunk();
        walk      = W_HDR;
        body_left = '0;
        hdr_word  = '0;
        chunk_len = '0;
    endfunction

    // Close a chunk body: commit or reject fmt, then pad or next header
    function automatic void close_body();
        if (walk == W_FMT && fmt_code_bad) begin
            latch_error(ST_NOT_PCM);
        end else begin
            if (walk == W_FMT) begin
                have_fmt = 1'b1;
            end
            if (pad_due) begin
                walk = W_PAD;
            end else begin
                next_chunk();
            end
        end
    endfunction

    // Advance the walk by one byte and form the result item it causes
    function automatic t_out_item parse_wav_byte(input logic [7:0] b, input logic is_final);
        t_out_item   r;
        logic [31:0] fpos;
        logic [31:0] bps;
        t_status     st;
        r = '0;
        case (walk)
            W_RIFF: begin
                hdr_word = {hdr_word[23:0], b};
                if (pos_cnt == 32'd3 && hdr_word != TAG_RIFF) begin
                    latch_error(ST_NOT_WAVE);
                end else if (pos_cnt == 32'd11) begin
                    if (hdr_word != TAG_WAVE) begin
                        latch_error(ST_NOT_WAVE);
                    end else begin
                        next_chunk();
                    end
                end
            end
            W_HDR: begin
                if (body_left < 4) begin
                    hdr_word = {hdr_word[23:0], b};
                end else begin
                    chunk_len = chunk_len | ({24'd0, b} << (8 * (body_left - 4)));
                end
                body_left++;
                // Header complete: pick how to treat the body
                if (body_left >= 8) begin
                    pad_due   = chunk_len[0];
                    body_left = {1'b0, chunk_len};
                    if (hdr_word == TAG_FMT) begin
                        if (chunk_len < FMT_MIN_LEN) begin
                            latch_error(ST_BAD_FMT);
                        end else begin
                            walk         = W_FMT;
                            fmt_code_bad = 1'b0;
                        end
                    end else if (hdr_word == TAG_DATA && !have_data) begin
                        have_data = 1'b1;
                        walk      = W_DATA;
                    end else begin
                        walk = W_SKIP;
                    end
                    if (walk != W_STOP && body_left == 0) begin
                        close_body();
                    end
                end
            end
            W_FMT, W_DATA, W_SKIP: begin
                if (walk == W_FMT) begin
                    fpos = chunk_len - body_left[31:0];
                    case (fpos)
                        0:  fmt_code_bad = (b != 8'd1);
                        1:  fmt_code_bad = fmt_code_bad || (b != 8'd0);
                        2:  fmt_chan[7:0]   = b;
                        3:  fmt_chan[15:8]  = b;
                        4:  fmt_rate[7:0]   = b;
                        5:  fmt_rate[15:8]  = b;
                        6:  fmt_rate[23:16] = b;
                        7:  fmt_rate[31:24] = b;
                        14: fmt_bits[7:0]   = b;
                        15: fmt_bits[15:8]  = b;
                        default: ;
                    endcase
                end else if (walk == W_DATA) begin
                    r.pcm_valid = 1'b1;
                    r.pcm_byte  = b;
                    if (pcm_count != '1) begin
                        pcm_count++;
                    end
                end
                if (body_left > 0) begin
                    body_left--;
                end
                if (body_left == 0) begin
                    close_body();
                end
            end
            W_PAD: begin
                next_chunk();
            end
            default: ;
        endcase

        if (pos_cnt != '1) begin
            pos_cnt++;
        end

        // Summary on the final byte, then back to the RIFF tag
        if (is_final) begin
            bps = {19'd0, fmt_bits[15:3]};
            if (pos_cnt < MIN_FILE_BYTES_DEF) begin
                st = ST_TOO_SMALL;
            end else if (latched_st != ST_OK) begin
                st = latched_st;
            end else if (walk == W_FMT) begin
                st = ST_BAD_FMT;
            end else if (!have_fmt || !have_data || pcm_count == 0) begin
                st = ST_MISSING;
            end else if (bps == 0 || fmt_chan == 0) begin
                st = ST_BAD_FMT;
            end else begin
                st = ST_OK;
            end
            r.done_res = 1'b1;
            r.status   = st;
            if (st == ST_OK) begin
                r.channels      = fmt_chan;
                r.rate_hz       = fmt_rate;
                r.sample_depth  = fmt_bits;
                r.data_length   = pcm_count;
                r.sample_frames = (pcm_count / bps) / {16'd0, fmt_chan};
            end
            clear_parser();
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Byte driver: offer pending items, predict on each accepted one
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            in_if.data  <= '0;
            clear_parser();
        end else begin
            if (in_if.valid && in_if.ready) begin
                exp_q.push_back(parse_wav_byte(in_if.data.file_byte, in_if.data.final_byte));
            end
            if (!in_if.valid || in_if.ready) begin
                if (pend_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    in_if.valid <= 1'b1;
                    in_if.data  <= pend_q.pop_front();
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: compare each accepted result with the oldest expected one
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("expected %0h, actual %0h in field %0s", want, got, name);
            err_cnt++;
        end
    endtask

    always @(posedge i_clk) begin : result_monitor
        t_out_item want;
        t_out_item got;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                got = out_if.data;
                if (exp_q.size() == 0) begin
                    $error("result item with nothing expected: %h", got);
                    err_cnt++;
                end else begin
                    want = exp_q.pop_front();
                    check_field("pcm_valid",     32'(want.pcm_valid),     32'(got.pcm_valid));
                    check_field("pcm_byte",      32'(want.pcm_byte),      32'(got.pcm_byte));
                    check_field("done_res",      32'(want.done_res),      32'(got.done_res));
                    check_field("status",        32'(want.status),        32'(got.status));
                    check_field("channels",      32'(want.channels),      32'(got.channels));
                    check_field("rate_hz",       want.rate_hz,            got.rate_hz);
                    check_field("sample_depth",  32'(want.sample_depth),  32'(got.sample_depth));
                    check_field("data_length",   want.data_length,        got.data_length);
                    check_field("sample_frames", want.sample_frames,      got.sample_frames);
                end
            end
            out_if.ready <= !hold_rx && ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Hold the receiver off for a long stretch once asked
    initial begin : rx_holdoff
        hold_rx = 1'b0;
        wait (start_hold);
        @(posedge i_clk);
        hold_rx <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_rx <= 1'b0;
    end

    // ------------------------------------------------------------------
    // File builders
    // ------------------------------------------------------------------
    task automatic put_tag(input logic [31:0] t);
        file_buf.push_back(t[31:24]);
        file_buf.push_back(t[23:16]);
        file_buf.push_back(t[15:8]);
        file_buf.push_back(t[7:0]);
    endtask

    task automatic put_le(input logic [31:0] v, input int n);
        for (int i = 0; i < n; i++) begin
            file_buf.push_back(v[8*i +: 8]);
        end
    endtask

    task automatic put_rand(input int n);
        for (int i = 0; i < n; i++) begin
            file_buf.push_back(8'($urandom_range(255)));
        end
    endtask

    task automatic begin_wav();
        put_tag(TAG_RIFF);
        put_le($urandom, 4);
        put_tag(TAG_WAVE);
    endtask

    // Chunk with a random body and its pad byte
    task automatic put_chunk(input logic [31:0] tag, input int len);
        put_tag(tag);
        put_le(len, 4);
        put_rand(len + (len % 2));
    endtask

    task automatic put_fmt(input logic [15:0] code, input logic [15:0] chan,
                           input logic [31:0] rate, input logic [15:0] bits,
                           input int extra);
        put_tag(TAG_FMT);
        put_le(16 + extra, 4);
        put_le({16'd0, code}, 2);
        put_le({16'd0, chan}, 2);
        put_le(rate, 4);
        put_rand(6);
        put_le({16'd0, bits}, 2);
        put_rand(extra + (extra % 2));
    endtask

    // Queue the first keep bytes of the buffer as one file
    task automatic ship_file(input int keep);
        t_in_item it;
        for (int i = 0; i < keep; i++) begin
            it.file_byte  = file_buf[i];
            it.final_byte = (i == keep - 1);
            pend_q.push_back(it);
        end
        items_sent += keep;
        file_buf.delete();
    endtask

    // WAV file with random content and chunk layout; some format fields may be bad
    task automatic build_wav();
        logic [15:0] code;
        logic [15:0] chan;
        logic [15:0] bits;
        int          extra;
        begin_wav();
        if ($urandom_range(3) == 0) begin
            put_chunk($urandom, $urandom_range(9));
        end
        code = ($urandom_range(15) == 0) ? 16'($urandom_range(65535)) : 16'd1;
        case ($urandom_range(9))
            0:       chan = 16'd0;
            1:       chan = 16'($urandom_range(65535));
            2, 3:    chan = 16'($urandom_range(1, 8));
            default: chan = 16'($urandom_range(1, 2));
        endcase
        case ($urandom_range(9))
            0:       bits = 16'($urandom_range(15));
            1:       bits = 16'($urandom_range(65535));
            default: bits = 16'(8 * $urandom_range(1, 4));
        endcase
        extra = ($urandom_range(3) == 0) ? $urandom_range(1, 6) : 0;
        put_fmt(code, chan, $urandom, bits, extra);
        if ($urandom_range(4) == 0) begin
            put_chunk(TAG_LIST, $urandom_range(7));
        end
        put_chunk(TAG_DATA, ($urandom_range(7) == 0) ? $urandom_range(3) : $urandom_range(4, 48));
        case ($urandom_range(5))
            0:       put_chunk(TAG_DATA, $urandom_range(9));
            1:       put_fmt(16'd1, 16'($urandom_range(1, 4)), $urandom, 16'd16, 0);
            2:       put_chunk(TAG_LIST, $urandom_range(9));
            default: ;
        endcase
    endtask

    // Mostly well-formed files, some corrupted or cut, some noise
    task automatic random_file();
        int pick;
        int keep;
        pick = $urandom_range(99);
        if (pick < 70) begin
            build_wav();
            keep = ($urandom_range(5) == 0) ? $urandom_range(44, file_buf.size())
                                            : file_buf.size();
        end else if (pick < 85) begin
            build_wav();
            file_buf[$urandom_range(43)] = 8'($urandom_range(255));
            keep = $urandom_range(1, file_buf.size());
        end else begin
            if ($urandom_range(1)) begin
                put_tag(TAG_RIFF);
            end
            put_rand($urandom_range(1, 90));
            keep = file_buf.size();
        end
        ship_file(keep);
    endtask

    // Pause the sender until every expected result has come
    task automatic wait_drain();
        while (pend_q.size() != 0 || in_if.valid || exp_q.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic run_phase(input int tx, input int rx, input logic long_hold);
        int target;
        @(negedge i_clk);
        tx_idle_pct  = tx;
        rx_stall_pct = rx;
        if (long_hold) begin
            start_hold = 1'b1;
        end
        target = items_sent + PHASE_BYTES;
        while (items_sent < target) begin
            random_file();
            if ($urandom_range(7) == 0) begin
                wait_drain();
            end
        end
        wait_drain();
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        items_sent   = 0;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        start_hold   = 1'b0;
        i_rst_n      = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Plain stereo 16-bit file
        begin_wav();
        put_fmt(16'd1, 16'd2, 32'd44100, 16'd16, 0);
        put_chunk(TAG_DATA, 4);
        ship_file(file_buf.size());

        // Largest format fields
        begin_wav();
        put_fmt(16'd1, 16'hffff, 32'hffff_ffff, 16'hffff, 0);
        put_chunk(TAG_DATA, 40);
        ship_file(file_buf.size());

        // Odd chunks with pads, a skipped second data chunk, a later fmt
        begin_wav();
        put_chunk(TAG_LIST, 5);
        put_fmt(16'd1, 16'd1, 32'd8000, 16'd8, 1);
        put_chunk(TAG_DATA, 3);
        put_chunk(TAG_DATA, 6);
        put_fmt(16'd1, 16'd2, 32'd22050, 16'd16, 0);
        ship_file(file_buf.size());

        // Too small: one byte, and a valid start cut short
        put_rand(1);
        ship_file(1);
        begin_wav();
        put_fmt(16'd1, 16'd1, 32'd8000, 16'd8, 0);
        put_chunk(TAG_DATA, 2);
        ship_file(MIN_FILE_BYTES_DEF - 1);

        // Not RIFF, then not WAVE
        put_tag(TAG_RIFX);
        put_le($urandom, 4);
        put_tag(TAG_WAVE);
        put_fmt(16'd1, 16'd1, 32'd8000, 16'd8, 0);
        put_chunk(TAG_DATA, 8);
        ship_file(file_buf.size());
        put_tag(TAG_RIFF);
        put_le($urandom, 4);
        put_tag(TAG_AVI);
        put_fmt(16'd1, 16'd1, 32'd8000, 16'd8, 0);
        put_chunk(TAG_DATA, 8);
        ship_file(file_buf.size());

        // fmt body shorter than 16 bytes
        begin_wav();
        put_chunk(TAG_FMT, 14);
        put_chunk(TAG_DATA, 20);
        ship_file(file_buf.size());

        // Non-PCM format code
        begin_wav();
        put_fmt(16'd3, 16'd2, 32'd48000, 16'd32, 0);
        put_chunk(TAG_DATA, 8);
        ship_file(file_buf.size());

        // File ends inside a non-PCM fmt body
        begin_wav();
        put_fmt(16'd3, 16'd2, 32'd48000, 16'd16, 100);
        ship_file(60);

        // Data forwarded before a bad fmt latches an error
        begin_wav();
        put_chunk(TAG_DATA, 10);
        put_fmt(16'h0102, 16'd1, 32'd8000, 16'd8, 0);
        ship_file(file_buf.size());

        // Missing chunks: no data, empty data, no fmt
        begin_wav();
        put_fmt(16'd1, 16'd1, 32'd8000, 16'd8, 0);
        put_chunk(TAG_LIST, 20);
        ship_file(file_buf.size());
        begin_wav();
        put_fmt(16'd1, 16'd1, 32'd8000, 16'd8, 0);
        put_chunk(TAG_DATA, 0);
        put_chunk(TAG_LIST, 10);
        ship_file(file_buf.size());
        begin_wav();
        put_chunk(TAG_DATA, 40);
        ship_file(file_buf.size());

        // Zero divisors: bits below 8, then no channels
        begin_wav();
        put_fmt(16'd1, 16'd1, 32'd8000, 16'd7, 0);
        put_chunk(TAG_DATA, 12);
        ship_file(file_buf.size());
        begin_wav();
        put_fmt(16'd1, 16'd0, 32'd8000, 16'd16, 0);
        put_chunk(TAG_DATA, 12);
        ship_file(file_buf.size());

        // Huge data length cut to the bytes received
        begin_wav();
        put_fmt(16'd1, 16'd1, 32'd8000, 16'd8, 0);
        put_tag(TAG_DATA);
        put_le(32'hffff_ffff, 4);
        put_rand(30);
        ship_file(file_buf.size());

        // Chunk header cut off by the end of file
        begin_wav();
        put_fmt(16'd1, 16'd1, 32'd8000, 16'd8, 0);
        put_chunk(TAG_DATA, 10);
        put_tag(TAG_LIST);
        put_rand(2);
        ship_file(file_buf.size());
        wait_drain();

        // Random phases: no idling with a long receiver hold-off, then idling mixes
        run_phase(0, 0, 1'b1);
        run_phase(62, 0, 1'b0);
        run_phase(0, 62, 1'b0);
        run_phase(23, 23, 1'b0);

        wait_drain();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (err_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Stop a hung run
    initial begin : watchdog
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
